// ===== rtl/pxh_pkg.sv =====
// Shared types, codes and constants of the pixel hit histogrammer.
package pxh_pkg;

	// Default geometry and store sizes.
	localparam int COLUMNS_DEF   = 80;
	localparam int ROWS_DEF      = 336;
	localparam int PAR_SLOTS_DEF = 4;
	localparam int TDC_BINS_DEF  = 4096;

	// Fixed sizes of the small histograms and the tot range.
	localparam int SMALL_BINS = 16;
	localparam int SMALL_AW   = 4;
	localparam int TOT_LIMIT  = 15;

	// Configuration register widths and reset values.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 4;
	localparam logic [3:0] MAX_TOT_RST   = 4'd13;
	localparam logic [2:0] PAR_COUNT_RST = 3'd1;

	// Depth of the queue between the classifier and the update engine.
	localparam int Q_DEPTH = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IW-1:0] {
		CFG_EN_OCC    = 3'd0,
		CFG_EN_BCID   = 3'd1,
		CFG_EN_TOT    = 3'd2,
		CFG_EN_TDC    = 3'd3,
		CFG_MAX_TOT   = 3'd4,
		CFG_PAR_COUNT = 3'd5
	} cfg_reg_t;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_HIT  = 2'd0,
		CMD_SEED = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	// Read targets.
	typedef enum logic [1:0] {
		HS_OCC  = 2'd0,
		HS_BCID = 2'd1,
		HS_TOT  = 2'd2,
		HS_TDC  = 2'd3
	} hsel_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_COLUMN = 3'd1,
		ST_ROW    = 3'd2,
		ST_TOT    = 3'd3,
		ST_TDC    = 3'd4,
		ST_BCID   = 3'd5,
		ST_PAR    = 3'd6,
		ST_READ   = 3'd7
	} status_t;

	// Update engine states.
	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE  = 3'b010,
		B_EXEC  = 3'b100
	} back_state_t;

	// Decoded work for one item, handed from classifier to update engine.
	typedef struct packed {
		status_t status;
		logic    last;
		logic    inc_occ;
		logic    inc_bcid;
		logic    inc_tot;
		logic    inc_tdc;
		logic    rd_en;
		hsel_t   rd_sel;
	} ctl_t;

	// Address width for a store of the given depth.
	function automatic int addr_width(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== rtl/pxh_front.sv =====
// Front part: configuration registers, input acceptance and item classification.
module pxh_front import pxh_pkg::*; #(
	parameter int COLUMNS   = COLUMNS_DEF,
	parameter int ROWS      = ROWS_DEF,
	parameter int PAR_SLOTS = PAR_SLOTS_DEF,
	parameter int TDC_BINS  = TDC_BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// Input channel.
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] column,
	input  logic [9:0] row,
	input  logic [7:0] tot,
	input  logic [15:0] tdc,
	input  logic [7:0] rel_bcid,
	input  logic [7:0] par_index,
	input  logic [1:0] hist_select,
	input  logic [15:0] bin,
	input  logic last_in,
	// Configuration channel.
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	// Toward the queue.
	input  logic q_full,
	input  logic busy,
	output logic push,
	output ctl_t ctl,
	output logic [addr_width(COLUMNS*ROWS*PAR_SLOTS)-1:0] occ_addr,
	output logic [SMALL_AW-1:0] bcid_addr,
	output logic [SMALL_AW-1:0] tot_addr,
	output logic [addr_width(TDC_BINS)-1:0] tdc_addr
);

	localparam int OCC_AW = addr_width(COLUMNS*ROWS*PAR_SLOTS);
	localparam int TDC_AW = addr_width(TDC_BINS);
	localparam logic [OCC_AW-1:0] COL_K   = OCC_AW'(COLUMNS);
	localparam logic [OCC_AW-1:0] PLANE_K = OCC_AW'(COLUMNS*ROWS);

	logic       en_occ_q;
	logic       en_bcid_q;
	logic       en_tot_q;
	logic       en_tdc_q;
	logic [3:0] max_tot_q;
	logic [2:0] par_count_q;

	logic col_ok, row_ok, tot_ok, tdc_ok, bcid_ok, slot_ok, par_ok, cut;
	logic bin_small_ok, bin_tdc_ok;
	logic [7:0] col_m1;
	logic [9:0] row_m1;
	logic is_read;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_occ_q    <= 1'b0;
			en_bcid_q   <= 1'b0;
			en_tot_q    <= 1'b0;
			en_tdc_q    <= 1'b0;
			max_tot_q   <= MAX_TOT_RST;
			par_count_q <= PAR_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EN_OCC:    en_occ_q    <= cfg_data[0];
				CFG_EN_BCID:   en_bcid_q   <= cfg_data[0];
				CFG_EN_TOT:    en_tot_q    <= cfg_data[0];
				CFG_EN_TDC:    en_tdc_q    <= cfg_data[0];
				CFG_MAX_TOT:   max_tot_q   <= cfg_data[3:0];
				CFG_PAR_COUNT: par_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Accept an item when the queue has room and the stores are not being cleared.
	assign in_stall = q_full | busy;
	assign push     = in_valid & ~in_stall;

	// Range checks on the item fields.
	assign col_ok       = (column != 8'd0) && ({1'b0, column} <= 9'(COLUMNS));
	assign row_ok       = (row != 10'd0) && ({1'b0, row} <= 11'(ROWS));
	assign tot_ok       = tot <= 8'(TOT_LIMIT);
	assign tdc_ok       = {1'b0, tdc} < 17'(TDC_BINS);
	assign bcid_ok      = rel_bcid < 8'(SMALL_BINS);
	assign slot_ok      = {1'b0, par_index} < 9'(PAR_SLOTS);
	assign par_ok       = slot_ok && (par_index < {5'd0, par_count_q});
	assign cut          = tot <= {4'd0, max_tot_q};
	assign bin_small_ok = bin < 16'(SMALL_BINS);
	assign bin_tdc_ok   = {1'b0, bin} < 17'(TDC_BINS);

	// Bin addresses; reads take the one-dimensional bin from the bin field.
	assign col_m1    = column - 8'd1;
	assign row_m1    = row - 10'd1;
	assign is_read   = cmd == CMD_READ;
	assign occ_addr  = OCC_AW'(col_m1) + OCC_AW'(row_m1) * COL_K
		+ OCC_AW'(par_index) * PLANE_K;
	assign bcid_addr = is_read ? bin[SMALL_AW-1:0] : rel_bcid[SMALL_AW-1:0];
	assign tot_addr  = is_read ? bin[SMALL_AW-1:0] : tot[SMALL_AW-1:0];
	assign tdc_addr  = is_read ? bin[TDC_AW-1:0] : tdc[TDC_AW-1:0];

	// Classify the item: status, which stores change and what is read.
	always_comb begin
		ctl          = '0;
		ctl.status   = ST_READ;
		ctl.last     = last_in;
		ctl.rd_sel   = hsel_t'(hist_select);
		unique case (cmd)
			CMD_HIT: begin
				if (!col_ok)       ctl.status = ST_COLUMN;
				else if (!row_ok)  ctl.status = ST_ROW;
				else if (!tot_ok)  ctl.status = ST_TOT;
				else if (!tdc_ok)  ctl.status = ST_TDC;
				else if (!bcid_ok) ctl.status = ST_BCID;
				else if (!par_ok)  ctl.status = ST_PAR;
				else               ctl.status = ST_OK;
				if (ctl.status == ST_OK) begin
					ctl.inc_occ  = en_occ_q & cut;
					ctl.inc_bcid = en_bcid_q & cut;
					ctl.inc_tot  = en_tot_q & cut;
					ctl.inc_tdc  = en_tdc_q;
				end
			end
			CMD_SEED: begin
				if (!col_ok)      ctl.status = ST_COLUMN;
				else if (!row_ok) ctl.status = ST_ROW;
				else if (!par_ok) ctl.status = ST_PAR;
				else              ctl.status = ST_OK;
				ctl.inc_occ = (ctl.status == ST_OK) & en_occ_q;
			end
			CMD_READ: begin
				unique case (hist_select)
					HS_OCC:  ctl.rd_en = col_ok & row_ok & slot_ok;
					HS_BCID: ctl.rd_en = bin_small_ok;
					HS_TOT:  ctl.rd_en = bin_small_ok;
					HS_TDC:  ctl.rd_en = bin_tdc_ok;
					default: ctl.rd_en = 1'b0;
				endcase
				ctl.status = ctl.rd_en ? ST_OK : ST_READ;
			end
			default: ctl.status = ST_READ;
		endcase
	end

endmodule

// ===== rtl/pxh_queue.sv =====
// Short FIFO between the classifier and the update engine.
module pxh_queue import pxh_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] wdata,
	output logic full,
	input  logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int QAW = addr_width(Q_DEPTH);

	logic [WIDTH-1:0] slot_q [Q_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	assign full  = cnt_q == (QAW+1)'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(Q_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(Q_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// A transfer into a full queue or out of an empty one would lose or invent items.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue read while empty");

endmodule

// ===== rtl/pxh_back.sv =====
// Back part: histogram memories, clearing pass, read-modify-write and result register.
module pxh_back import pxh_pkg::*; #(
	parameter int COLUMNS   = COLUMNS_DEF,
	parameter int ROWS      = ROWS_DEF,
	parameter int PAR_SLOTS = PAR_SLOTS_DEF,
	parameter int TDC_BINS  = TDC_BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// From the queue.
	input  logic q_empty,
	output logic pop,
	input  ctl_t ctl_in,
	input  logic [addr_width(COLUMNS*ROWS*PAR_SLOTS)-1:0] occ_addr_in,
	input  logic [SMALL_AW-1:0] bcid_addr_in,
	input  logic [SMALL_AW-1:0] tot_addr_in,
	input  logic [addr_width(TDC_BINS)-1:0] tdc_addr_in,
	output logic busy,
	// Result channel.
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic [31:0] count,
	output logic last_out
);

	localparam int OCC_DEPTH = COLUMNS*ROWS*PAR_SLOTS;
	localparam int OCC_AW    = addr_width(OCC_DEPTH);
	localparam int TDC_AW    = addr_width(TDC_BINS);
	localparam int CLR_DEPTH = (OCC_DEPTH > TDC_BINS) ? OCC_DEPTH : TDC_BINS;
	localparam int CLR_AW    = addr_width(CLR_DEPTH);

	logic [31:0] occ_mem  [OCC_DEPTH];
	logic [31:0] bcid_mem [SMALL_BINS];
	logic [31:0] tot_mem  [SMALL_BINS];
	logic [31:0] tdc_mem  [TDC_BINS];

	back_state_t         state_q;
	logic [CLR_AW-1:0]   clr_q;
	ctl_t                ctl_q;
	logic [OCC_AW-1:0]   occ_addr_q;
	logic [SMALL_AW-1:0] bcid_addr_q;
	logic [SMALL_AW-1:0] tot_addr_q;
	logic [TDC_AW-1:0]   tdc_addr_q;
	logic [31:0]         occ_rd_q, bcid_rd_q, tot_rd_q, tdc_rd_q;
	logic                res_valid_q;
	logic [2:0]          status_q;
	logic [31:0]         count_q;
	logic                last_q;

	logic clearing, go, clr_last;
	logic occ_we, bcid_we, tot_we, tdc_we;
	logic [OCC_AW-1:0]   occ_wa;
	logic [SMALL_AW-1:0] bcid_wa, tot_wa;
	logic [TDC_AW-1:0]   tdc_wa;
	logic [31:0]         occ_wd, bcid_wd, tot_wd, tdc_wd;
	logic [31:0]         rd_sel_data;

	assign clearing = state_q == B_CLEAR;
	assign busy     = clearing;
	assign clr_last = clr_q == CLR_AW'(CLR_DEPTH-1);
	assign pop      = (state_q == B_IDLE) && !q_empty;
	// The write and the result load happen together once the result register is free.
	assign go       = (state_q == B_EXEC) && (!res_valid_q || !out_stall);

	// Write ports: zero during the clearing pass, the incremented count afterwards.
	assign occ_we  = clearing ? ({1'b0, clr_q} < (CLR_AW+1)'(OCC_DEPTH)) : (go & ctl_q.inc_occ);
	assign bcid_we = clearing ? ({1'b0, clr_q} < (CLR_AW+1)'(SMALL_BINS)) : (go & ctl_q.inc_bcid);
	assign tot_we  = clearing ? ({1'b0, clr_q} < (CLR_AW+1)'(SMALL_BINS)) : (go & ctl_q.inc_tot);
	assign tdc_we  = clearing ? ({1'b0, clr_q} < (CLR_AW+1)'(TDC_BINS)) : (go & ctl_q.inc_tdc);
	assign occ_wa  = clearing ? clr_q[OCC_AW-1:0] : occ_addr_q;
	assign bcid_wa = clearing ? clr_q[SMALL_AW-1:0] : bcid_addr_q;
	assign tot_wa  = clearing ? clr_q[SMALL_AW-1:0] : tot_addr_q;
	assign tdc_wa  = clearing ? clr_q[TDC_AW-1:0] : tdc_addr_q;
	assign occ_wd  = clearing ? '0 : occ_rd_q + 32'd1;
	assign bcid_wd = clearing ? '0 : bcid_rd_q + 32'd1;
	assign tot_wd  = clearing ? '0 : tot_rd_q + 32'd1;
	assign tdc_wd  = clearing ? '0 : tdc_rd_q + 32'd1;

	// Histogram memories; each is read when an item leaves the queue.
	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		if (pop) begin
			occ_rd_q <= occ_mem[occ_addr_in];
		end
	end

	always_ff @(posedge clk) begin
		if (bcid_we) begin
			bcid_mem[bcid_wa] <= bcid_wd;
		end
		if (pop) begin
			bcid_rd_q <= bcid_mem[bcid_addr_in];
		end
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			tot_mem[tot_wa] <= tot_wd;
		end
		if (pop) begin
			tot_rd_q <= tot_mem[tot_addr_in];
		end
	end

	always_ff @(posedge clk) begin
		if (tdc_we) begin
			tdc_mem[tdc_wa] <= tdc_wd;
		end
		if (pop) begin
			tdc_rd_q <= tdc_mem[tdc_addr_in];
		end
	end

	// Item held for the write-back cycle.
	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_q       <= ctl_in;
			occ_addr_q  <= occ_addr_in;
			bcid_addr_q <= bcid_addr_in;
			tot_addr_q  <= tot_addr_in;
			tdc_addr_q  <= tdc_addr_in;
		end
	end

	// Count returned by a read.
	always_comb begin
		unique case (ctl_q.rd_sel)
			HS_OCC:  rd_sel_data = occ_rd_q;
			HS_BCID: rd_sel_data = bcid_rd_q;
			HS_TOT:  rd_sel_data = tot_rd_q;
			HS_TDC:  rd_sel_data = tdc_rd_q;
			default: rd_sel_data = '0;
		endcase
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= ctl_q.status;
			count_q  <= ctl_q.rd_en ? rd_sel_data : '0;
			last_q   <= ctl_q.last;
		end
	end

	// Sequencer: clearing pass after reset, then read and write-back per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					if (go) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = res_valid_q;
	assign status    = status_q;
	assign count     = count_q;
	assign last_out  = last_q;

	// A finished item always shows up as a result in the next cycle.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> res_valid_q)
		else $error("write-back without result");
	// A blocked write-back keeps its item and does not write twice.
	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EXEC && !go) |=> (state_q == B_EXEC && $stable(ctl_q)))
		else $error("write-back item lost while result blocked");
	// No item reaches the queue while the stores are being cleared.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> q_empty)
		else $error("item queued during clearing pass");

endmodule

// ===== rtl/pixel_hit_histogrammer_unit.sv =====
// Top level of the pixel hit histogrammer: classifier, queue and update engine.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     cmd column row tot tdc rel_bcid par_index
//                                              hist_select bin last_in
// out       output     out_valid / out_stall   status count last_out
// cfg       input      cfg_valid / cfg_ready   cfg_index cfg_data
//
// Each item passes two steps in the update engine: a memory read when it leaves
// the queue, then the increment write-back and the result load. No new item
// leaves the queue until the last one is written back, set by the single
// read-modify-write of the stores. A clearing pass after reset zeroes all stores
// over max(COLUMNS*ROWS*PAR_SLOTS, TDC_BINS) addresses (107520 by default), with
// in_stall high. The two-entry queue keeps accepting while the engine waits on out_stall.
module pixel_hit_histogrammer_unit import pxh_pkg::*; #(
	parameter int COLUMNS   = COLUMNS_DEF,
	parameter int ROWS      = ROWS_DEF,
	parameter int PAR_SLOTS = PAR_SLOTS_DEF,
	parameter int TDC_BINS  = TDC_BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] column,
	input  logic [9:0] row,
	input  logic [7:0] tot,
	input  logic [15:0] tdc,
	input  logic [7:0] rel_bcid,
	input  logic [7:0] par_index,
	input  logic [1:0] hist_select,
	input  logic [15:0] bin,
	input  logic last_in,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic [31:0] count,
	output logic last_out,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam int OCC_AW = addr_width(COLUMNS*ROWS*PAR_SLOTS);
	localparam int TDC_AW = addr_width(TDC_BINS);
	localparam int Q_W    = $bits(ctl_t) + OCC_AW + 2*SMALL_AW + TDC_AW;

	logic q_full, q_empty, push, pop, busy;
	ctl_t f_ctl, q_ctl;
	logic [OCC_AW-1:0]   f_occ, q_occ;
	logic [SMALL_AW-1:0] f_bcid, q_bcid, f_tot, q_tot;
	logic [TDC_AW-1:0]   f_tdc, q_tdc;
	logic [Q_W-1:0]      q_wdata, q_rdata;

	// Classifier.
	pxh_front #(
		.COLUMNS(COLUMNS), .ROWS(ROWS), .PAR_SLOTS(PAR_SLOTS), .TDC_BINS(TDC_BINS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .column(column), .row(row), .tot(tot), .tdc(tdc),
		.rel_bcid(rel_bcid), .par_index(par_index), .hist_select(hist_select),
		.bin(bin), .last_in(last_in),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_full(q_full), .busy(busy), .push(push), .ctl(f_ctl),
		.occ_addr(f_occ), .bcid_addr(f_bcid), .tot_addr(f_tot), .tdc_addr(f_tdc)
	);

	// Queue entry packing.
	assign q_wdata = {f_ctl, f_occ, f_bcid, f_tot, f_tdc};
	assign {q_ctl, q_occ, q_bcid, q_tot, q_tdc} = q_rdata;

	pxh_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(q_wdata), .full(q_full),
		.pop(pop), .rdata(q_rdata), .empty(q_empty)
	);

	// Update engine.
	pxh_back #(
		.COLUMNS(COLUMNS), .ROWS(ROWS), .PAR_SLOTS(PAR_SLOTS), .TDC_BINS(TDC_BINS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .pop(pop), .ctl_in(q_ctl),
		.occ_addr_in(q_occ), .bcid_addr_in(q_bcid), .tot_addr_in(q_tot),
		.tdc_addr_in(q_tdc), .busy(busy),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .count(count), .last_out(last_out)
	);

endmodule

// ===== tb/tb_pixel_hit_histogrammer_unit.sv =====
// Self-checking testbench for the pixel hit histogrammer: directed table, then random phases.
module tb_pixel_hit_histogrammer_unit import pxh_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS   = COLUMNS_DEF;
	localparam int ROWS      = ROWS_DEF;
	localparam int PAR_SLOTS = PAR_SLOTS_DEF;
	localparam int TDC_BINS  = TDC_BINS_DEF;
	localparam int OCC_DEPTH = COLUMNS * ROWS * PAR_SLOTS;

	// Codes the package leaves unnamed: the unused command and a spare register index.
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [CFG_IW-1:0] CFG_SPARE = 3'd6;

	// The limit covers the clearing pass over OCC_DEPTH addresses with a wide margin.
	localparam int CYCLE_LIMIT     = 600000;
	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int POOL_SIZE       = 8;
	localparam int TAIL_CYCLES     = 16;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  column;
		logic [9:0]  row;
		logic [7:0]  tot;
		logic [15:0] tdc;
		logic [7:0]  rel_bcid;
		logic [7:0]  par_index;
		hsel_t       hist_select;
		logic [15:0] bin;
		logic        last;
	} hit_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] count;
		logic        last;
	} bin_result_t;

	typedef struct {
		bit                 is_cfg;
		logic [CFG_IW-1:0]  reg_idx;
		logic [CFG_DW-1:0]  reg_data;
		hit_item_t          item;
		bit                 typed;
		status_t            status;
		logic [31:0]        count;
	} directed_step_t;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [7:0]  column;
	logic [9:0]  row;
	logic [7:0]  tot;
	logic [15:0] tdc;
	logic [7:0]  rel_bcid;
	logic [7:0]  par_index;
	logic [1:0]  hist_select;
	logic [15:0] bin;
	logic        last_in;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] count;
	logic        last_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	// Shadow of the histogram stores and the registers.
	bit [31:0] occ_counts [OCC_DEPTH];
	bit [31:0] bcid_counts [SMALL_BINS];
	bit [31:0] tot_counts [SMALL_BINS];
	bit [31:0] tdc_counts [TDC_BINS];
	bit        en_occ;
	bit        en_bcid;
	bit        en_tot;
	bit        en_tdc;
	bit [3:0]  max_tot_cfg;
	bit [2:0]  par_count_cfg;

	bin_result_t    pending_results[$];
	directed_step_t directed_steps[$];
	int             error_count;
	int             cycle_count;
	int             burst_left;
	logic [7:0]     pool_col [POOL_SIZE];
	logic [9:0]     pool_row [POOL_SIZE];

	pixel_hit_histogrammer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .column(column), .row(row), .tot(tot), .tdc(tdc),
		.rel_bcid(rel_bcid), .par_index(par_index), .hist_select(hist_select),
		.bin(bin), .last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .count(count), .last_out(last_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Column and row check shared by hits, seeds and occupancy reads.
	function automatic status_t pixel_status(input logic [7:0] c, input logic [9:0] r);
		if (c < 1 || c > COLUMNS)
			return ST_COLUMN;
		if (r < 1 || r > ROWS)
			return ST_ROW;
		return ST_OK;
	endfunction

	function automatic bit slot_in_use(input logic [7:0] p);
		return p < par_count_cfg && p < PAR_SLOTS;
	endfunction

	function automatic int unsigned occ_index(input hit_item_t it);
		return (it.column - 1) + (it.row - 1) * COLUMNS + it.par_index * COLUMNS * ROWS;
	endfunction

	// Applies one item to the shadow stores and returns the result it should give.
	function automatic bin_result_t histogram_step(input hit_item_t it);
		bin_result_t res;
		bit          cut;
		res.status = ST_OK;
		res.count = '0;
		res.last = it.last;
		case (it.cmd)
			CMD_HIT: begin
				res.status = pixel_status(it.column, it.row);
				if (res.status == ST_OK && it.tot > TOT_LIMIT)
					res.status = ST_TOT;
				if (res.status == ST_OK && it.tdc >= TDC_BINS)
					res.status = ST_TDC;
				if (res.status == ST_OK && it.rel_bcid >= SMALL_BINS)
					res.status = ST_BCID;
				if (res.status == ST_OK && !slot_in_use(it.par_index))
					res.status = ST_PAR;
				if (res.status == ST_OK) begin
					cut = it.tot <= max_tot_cfg;
					if (en_occ && cut)
						occ_counts[occ_index(it)] += 1;
					if (en_bcid && cut)
						bcid_counts[it.rel_bcid] += 1;
					if (en_tot && cut)
						tot_counts[it.tot] += 1;
					if (en_tdc)
						tdc_counts[it.tdc] += 1;
				end
			end
			CMD_SEED: begin
				res.status = pixel_status(it.column, it.row);
				if (res.status == ST_OK && !slot_in_use(it.par_index))
					res.status = ST_PAR;
				if (res.status == ST_OK && en_occ)
					occ_counts[occ_index(it)] += 1;
			end
			CMD_READ: begin
				res.status = ST_READ;
				case (it.hist_select)
					HS_OCC: begin
						if (pixel_status(it.column, it.row) == ST_OK
								&& it.par_index < PAR_SLOTS) begin
							res.count = occ_counts[occ_index(it)];
							res.status = ST_OK;
						end
					end
					HS_BCID: begin
						if (it.bin < SMALL_BINS) begin
							res.count = bcid_counts[it.bin];
							res.status = ST_OK;
						end
					end
					HS_TOT: begin
						if (it.bin < SMALL_BINS) begin
							res.count = tot_counts[it.bin];
							res.status = ST_OK;
						end
					end
					default: begin
						if (it.bin < TDC_BINS) begin
							res.count = tdc_counts[it.bin];
							res.status = ST_OK;
						end
					end
				endcase
			end
			default: begin
				res.status = ST_READ;
			end
		endcase
		return res;
	endfunction

	function automatic hit_item_t mk_item(input logic [1:0] c, input int col, input int r,
			input int t, input int d, input int b, input int p, input hsel_t sel,
			input int bn, input bit l);
		hit_item_t it;
		it.cmd = c;
		it.column = 8'(col);
		it.row = 10'(r);
		it.tot = 8'(t);
		it.tdc = 16'(d);
		it.rel_bcid = 8'(b);
		it.par_index = 8'(p);
		it.hist_select = sel;
		it.bin = 16'(bn);
		it.last = l;
		return it;
	endfunction

	task automatic add_item_row(input hit_item_t it, input bit typed, input status_t st,
			input logic [31:0] cnt);
		directed_step_t s;
		s.is_cfg = 1'b0;
		s.reg_idx = '0;
		s.reg_data = '0;
		s.item = it;
		s.typed = typed;
		s.status = st;
		s.count = cnt;
		directed_steps.insert(directed_steps.size(), s);
	endtask

	task automatic add_cfg_row(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		directed_step_t s;
		s.is_cfg = 1'b1;
		s.reg_idx = idx;
		s.reg_data = data;
		s.item = '0;
		s.typed = 1'b0;
		s.status = ST_OK;
		s.count = '0;
		directed_steps.insert(directed_steps.size(), s);
	endtask

	// Mostly well-formed items on a small pool of pixels, so that reads find counts.
	function automatic hit_item_t random_item();
		hit_item_t   it;
		int unsigned pick;
		int unsigned slot;
		pick = $urandom_range(0, 99);
		slot = $urandom_range(0, POOL_SIZE - 1);
		it.cmd = (pick < 45) ? CMD_HIT : (pick < 60) ? CMD_SEED : (pick < 95) ? CMD_READ
			: CMD_SPARE;
		if ($urandom_range(0, 99) < 80) begin
			it.column = pool_col[slot];
			it.row = pool_row[slot];
		end else begin
			it.column = 8'($urandom);
			it.row = 10'($urandom);
		end
		it.tot = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15)) : 8'($urandom);
		pick = $urandom_range(0, 99);
		it.tdc = (pick < 60) ? 16'($urandom_range(0, 15))
			: (pick < 88) ? 16'($urandom_range(0, TDC_BINS - 1)) : 16'($urandom);
		it.rel_bcid = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
			: 8'($urandom);
		it.par_index = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, PAR_SLOTS - 1))
			: 8'($urandom);
		it.hist_select = hsel_t'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (it.hist_select == HS_TDC && pick >= 60 && pick < 88)
			it.bin = 16'($urandom_range(0, TDC_BINS - 1));
		else
			it.bin = (pick < 88) ? 16'($urandom_range(0, 15)) : 16'($urandom);
		it.last = 1'($urandom);
		return it;
	endfunction

	// Presents one item and holds it until the transfer; the expectation is taken then.
	task automatic drive_item(input hit_item_t it, input bit typed, input status_t st,
			input logic [31:0] cnt);
		bin_result_t want;
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= it.cmd;
		column <= it.column;
		row <= it.row;
		tot <= it.tot;
		tdc <= it.tdc;
		rel_bcid <= it.rel_bcid;
		par_index <= it.par_index;
		hist_select <= it.hist_select;
		bin <= it.bin;
		last_in <= it.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = histogram_step(it);
		if (typed) begin
			want.status = st;
			want.count = cnt;
		end
		pending_results.insert(pending_results.size(), want);
	endtask

	// Sender bursts: a random run of back-to-back transfers, then a random gap.
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_EN_OCC:    en_occ = data[0];
			CFG_EN_BCID:   en_bcid = data[0];
			CFG_EN_TOT:    en_tot = data[0];
			CFG_EN_TDC:    en_tdc = data[0];
			CFG_MAX_TOT:   max_tot_cfg = data;
			CFG_PAR_COUNT: par_count_cfg = data[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver stalls: modes of random length, from wide open to mostly stalled.
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		int       phase;
		mode = RX_OPEN;
		mode_left = 0;
		phase = 0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			phase++;
			case (mode)
				RX_OPEN:     out_stall <= 1'b0;
				RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: out_stall <= (phase % 3 == 0);
			endcase
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : check_results
		bin_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d, count %0d, last_out %0b",
					status, count, last_out);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, status);
					error_count++;
				end
				if (count !== want.count) begin
					$error("count mismatch: expected %0d, actual %0d", want.count, count);
					error_count++;
				end
				if (last_out !== want.last) begin
					$error("last_out mismatch: expected %0b, actual %0b", want.last, last_out);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int p;
		int n;
		in_valid <= 1'b0;
		cmd <= CMD_HIT;
		column <= '0;
		row <= '0;
		tot <= '0;
		tdc <= '0;
		rel_bcid <= '0;
		par_index <= '0;
		hist_select <= HS_OCC;
		bin <= '0;
		last_in <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_EN_OCC;
		cfg_data <= '0;
		arst_n <= 1'b0;
		error_count = 0;
		cycle_count = 0;
		burst_left = 0;
		en_occ = 1'b0;
		en_bcid = 1'b0;
		en_tot = 1'b0;
		en_tdc = 1'b0;
		max_tot_cfg = MAX_TOT_RST;
		par_count_cfg = PAR_COUNT_RST;

		// Directed rows: reset state, each failing check, bad reads, edge bins and cuts.
		add_item_row(mk_item(CMD_READ, 1, 1, 0, 0, 0, 0, HS_OCC, 0, 0), 1, ST_OK, 0);
		add_item_row(mk_item(CMD_HIT, 1, 1, 0, 0, 0, 0, HS_OCC, 0, 1), 1, ST_OK, 0);
		add_item_row(mk_item(CMD_READ, 1, 1, 0, 0, 0, 0, HS_OCC, 0, 0), 1, ST_OK, 0);
		add_item_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, HS_TDC, 0, 0), 1, ST_OK, 0);
		add_item_row(mk_item(CMD_HIT, 0, 1, 0, 0, 0, 0, HS_OCC, 0, 0), 1, ST_COLUMN, 0);
		add_item_row(mk_item(CMD_HIT, 255, 1023, 255, 65535, 255, 255, HS_TDC, 65535, 1),
			1, ST_COLUMN, 0);
		add_item_row(mk_item(CMD_HIT, 1, 0, 0, 0, 0, 0, HS_OCC, 0, 0), 1, ST_ROW, 0);
		add_item_row(mk_item(CMD_HIT, COLUMNS, ROWS + 1, 255, 0, 0, 0, HS_OCC, 0, 0),
			1, ST_ROW, 0);
		add_item_row(mk_item(CMD_HIT, 1, 1, 16, 65535, 0, 0, HS_OCC, 0, 0), 1, ST_TOT, 0);
		add_item_row(mk_item(CMD_HIT, 1, 1, 0, TDC_BINS, 255, 0, HS_OCC, 0, 0), 1, ST_TDC, 0);
		add_item_row(mk_item(CMD_HIT, 1, 1, 0, 0, 16, 255, HS_OCC, 0, 0), 1, ST_BCID, 0);
		add_item_row(mk_item(CMD_HIT, 1, 1, 0, 0, 0, 1, HS_OCC, 0, 0), 1, ST_PAR, 0);
		add_item_row(mk_item(CMD_SEED, 0, 1, 0, 0, 0, 0, HS_OCC, 0, 0), 1, ST_COLUMN, 0);
		add_item_row(mk_item(CMD_SEED, 1, 1, 255, 0, 0, 255, HS_OCC, 0, 0), 1, ST_PAR, 0);
		add_item_row(mk_item(CMD_SPARE, 1, 1, 0, 0, 0, 0, HS_OCC, 0, 1), 1, ST_READ, 0);
		add_item_row(mk_item(CMD_READ, 1, 1, 0, 0, 0, 0, HS_BCID, 16, 0), 1, ST_READ, 0);
		add_item_row(mk_item(CMD_READ, 1, 1, 0, 0, 0, 0, HS_TDC, 65535, 0), 1, ST_READ, 0);
		add_item_row(mk_item(CMD_READ, 1, 1, 0, 0, 0, PAR_SLOTS, HS_OCC, 0, 0),
			1, ST_READ, 0);
		add_item_row(mk_item(CMD_READ, 1, ROWS + 1, 0, 0, 0, 0, HS_OCC, 0, 0), 1, ST_READ, 0);
		add_cfg_row(CFG_EN_OCC, 4'd1);
		add_cfg_row(CFG_EN_BCID, 4'd1);
		add_cfg_row(CFG_EN_TOT, 4'd1);
		add_cfg_row(CFG_EN_TDC, 4'd1);
		add_cfg_row(CFG_MAX_TOT, 4'd15);
		add_cfg_row(CFG_PAR_COUNT, 4'd4);
		add_item_row(mk_item(CMD_HIT, COLUMNS, ROWS, 15, TDC_BINS - 1, 15, 3, HS_OCC, 0, 1),
			1, ST_OK, 0);
		add_item_row(mk_item(CMD_SEED, COLUMNS, ROWS, 0, 0, 0, 3, HS_OCC, 0, 0), 1, ST_OK, 0);
		add_item_row(mk_item(CMD_READ, COLUMNS, ROWS, 0, 0, 0, 3, HS_OCC, 0, 0), 1, ST_OK, 2);
		add_item_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, HS_TDC, TDC_BINS - 1, 0),
			1, ST_OK, 1);
		add_item_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, HS_BCID, 15, 0), 1, ST_OK, 1);
		add_item_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, HS_TOT, 15, 1), 1, ST_OK, 1);
		// With max_tot at zero, a tot of one is cut everywhere but the tdc store.
		add_cfg_row(CFG_MAX_TOT, 4'd0);
		add_item_row(mk_item(CMD_HIT, 1, 1, 1, 0, 0, 0, HS_OCC, 0, 0), 0, ST_OK, 0);
		add_item_row(mk_item(CMD_HIT, 1, 1, 0, 0, 0, 0, HS_OCC, 0, 0), 0, ST_OK, 0);
		add_item_row(mk_item(CMD_READ, 1, 1, 0, 0, 0, 0, HS_OCC, 0, 0), 0, ST_OK, 0);
		add_item_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, HS_TOT, 1, 0), 0, ST_OK, 0);
		add_item_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0, HS_TDC, 0, 0), 0, ST_OK, 0);
		// No slot in use at all, then more slots than the store holds.
		add_cfg_row(CFG_PAR_COUNT, 4'd0);
		add_item_row(mk_item(CMD_SEED, 1, 1, 0, 0, 0, 0, HS_OCC, 0, 0), 1, ST_PAR, 0);
		add_cfg_row(CFG_PAR_COUNT, 4'd7);
		add_cfg_row(CFG_SPARE, 4'd15);
		add_item_row(mk_item(CMD_HIT, 2, 2, 0, 0, 0, PAR_SLOTS, HS_OCC, 0, 0), 1, ST_PAR, 0);
		add_item_row(mk_item(CMD_HIT, 2, 2, 0, 0, 0, 3, HS_OCC, 0, 1), 0, ST_OK, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; register writes wait for the block to go idle.
		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg) begin
				drain_results();
				write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_data);
			end else begin
				drive_item(directed_steps[i].item, directed_steps[i].typed,
					directed_steps[i].status, directed_steps[i].count);
				pace();
			end
		end

		// Random phases, each under its own register setting and pixel pool.
		for (p = 0; p < PHASES; p++) begin
			drain_results();
			if (p == 0) begin
				write_reg(CFG_EN_OCC, 4'd1);
				write_reg(CFG_EN_BCID, 4'd1);
				write_reg(CFG_EN_TOT, 4'd1);
				write_reg(CFG_EN_TDC, 4'd1);
				write_reg(CFG_MAX_TOT, 4'd15);
				write_reg(CFG_PAR_COUNT, 4'd4);
			end else if (p == 1) begin
				write_reg(CFG_EN_OCC, 4'hF);
				write_reg(CFG_EN_BCID, 4'hF);
				write_reg(CFG_EN_TOT, 4'hF);
				write_reg(CFG_EN_TDC, 4'hE);
				write_reg(CFG_MAX_TOT, 4'd0);
				write_reg(CFG_PAR_COUNT, 4'd7);
			end else begin
				write_reg(CFG_EN_OCC, 4'($urandom));
				write_reg(CFG_EN_BCID, 4'($urandom));
				write_reg(CFG_EN_TOT, 4'($urandom));
				write_reg(CFG_EN_TDC, 4'($urandom));
				write_reg(CFG_MAX_TOT, 4'($urandom));
				write_reg(CFG_PAR_COUNT, 4'($urandom));
			end
			// Pool keeps both corner pixels and six random ones.
			pool_col[0] = 8'd1;
			pool_row[0] = 10'd1;
			pool_col[1] = 8'(COLUMNS);
			pool_row[1] = 10'(ROWS);
			for (n = 2; n < POOL_SIZE; n++) begin
				pool_col[n] = 8'($urandom_range(1, COLUMNS));
				pool_row[n] = 10'($urandom_range(1, ROWS));
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				drive_item(random_item(), 1'b0, ST_OK, '0);
				pace();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
